/* design/clebw_pkg.sv */
package clebw_pkg;

    localparam int NUM_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    localparam logic [1:0] OP_CMD  = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_NUM  = 2'd2;

    localparam logic [1:0] BUS_START = 2'd0;
    localparam logic [1:0] BUS_BYTE  = 2'd1;
    localparam logic [1:0] BUS_STOP  = 2'd2;

    localparam logic [7:0] ADDR_RESET = 8'd78;
    localparam logic [7:0] CURSOR_CMD = 8'hCA;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    typedef enum logic [1:0] {
        REC_CMD  = 2'd0,
        REC_DATA = 2'd1,
        REC_NUM  = 2'd2
    } rec_kind_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // One shift-and-add-3 step of binary to BCD conversion.
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b,
                                                 input logic in_bit);
        logic [BCD_W-1:0] a;
        a = b;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (a[4*i +: 4] >= 4'd5) begin
                a[4*i +: 4] = a[4*i +: 4] + 4'd3;
            end
        end
        return {a[BCD_W-2:0], in_bit};
    endfunction

    // Expander byte: nibble in bits 7..4, enable in bit 2, register select in bit 0.
    // sub[1] picks the low nibble, sub[0] drops enable.
    function automatic logic [7:0] lcd_byte(input logic [7:0] d, input logic rs,
                                            input logic [1:0] sub);
        logic [3:0] nib;
        nib = sub[1] ? d[3:0] : d[7:4];
        return {nib, 1'b0, ~sub[0], 1'b0, rs};
    endfunction

endpackage

/* design/clebw_front.sv */
module clebw_front
    import clebw_pkg::*;
#(
    parameter int DIGITS = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [NUM_W+BYTE_W-1:0]   s_tdata,
    input  logic [1:0]                s_tuser,
    output logic                      push_valid,
    output logic [4*DIGITS+BYTE_W+1:0] push_data,
    input  q_stat_t                   q_stat
);

    localparam int DD_STEPS = NUM_W / 2;
    localparam int CNT_W    = $clog2(DD_STEPS);

    logic             conv_reg, conv_next;
    logic             hold_reg, hold_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] sh_reg, sh_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic             accept;
    logic             conv_last;

    assign s_tready  = ~conv_reg & ~hold_reg & ~q_stat.full;
    assign accept    = s_tvalid & s_tready;
    assign conv_last = (cnt_reg == CNT_W'(DD_STEPS - 1));

    always_comb begin
        push_valid = 1'b0;
        push_data  = {bcd_reg[4*DIGITS-1:0], 8'd0, REC_NUM};
        if (hold_reg && !q_stat.full) begin
            push_valid = 1'b1;
        end else if (accept && (s_tuser == OP_CMD || s_tuser == OP_DATA)) begin
            push_valid = 1'b1;
            push_data  = {{(4*DIGITS){1'b0}}, s_tdata[BYTE_W-1:0],
                          (s_tuser == OP_DATA) ? REC_DATA : REC_CMD};
        end
    end

    always_comb begin
        conv_next = conv_reg;
        hold_next = hold_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        bcd_next  = bcd_reg;
        if (accept && s_tuser == OP_NUM) begin
            conv_next = 1'b1;
            cnt_next  = '0;
            sh_next   = s_tdata[NUM_W+BYTE_W-1:BYTE_W];
            bcd_next  = '0;
        end else if (conv_reg) begin
            // Two bits per cycle, most significant first.
            bcd_next = dd_step(dd_step(bcd_reg, sh_reg[NUM_W-1]), sh_reg[NUM_W-2]);
            sh_next  = {sh_reg[NUM_W-3:0], 2'b00};
            cnt_next = cnt_reg + 1'b1;
            if (conv_last) begin
                conv_next = 1'b0;
                hold_next = 1'b1;
            end
        end else if (hold_reg && !q_stat.full) begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conv_reg <= 1'b0;
            hold_reg <= 1'b0;
        end else begin
            conv_reg <= conv_next;
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
    end

endmodule

/* design/clebw_queue.sv */
module clebw_queue
    import clebw_pkg::*;
#(
    parameter int W = 34
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head_data,
    output q_stat_t      q_stat
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;

    assign head_data    = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == 2'd2);
    assign q_stat.empty = (cnt_reg == 2'd0);

    always_comb begin
        wr_ptr_next = push_valid ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push_valid} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/clebw_back.sv */
module clebw_back
    import clebw_pkg::*;
#(
    parameter int DIGITS = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [7:0]                 cfg_wdata,
    input  q_stat_t                    q_stat,
    input  logic [4*DIGITS+BYTE_W+1:0] head_data,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,
    output logic [1:0]                 m_tuser,
    output logic                       m_tlast
);

    localparam int STOP_STEP = 6 + 4 * DIGITS;
    localparam int STEP_W    = $clog2(STOP_STEP + 1);
    localparam int DIG_W     = 4 * DIGITS;

    logic [7:0]        addr_reg;
    logic              act_reg;
    rec_kind_t         kind_reg;
    logic [7:0]        byte_reg;
    logic [DIG_W-1:0]  bcd_reg;
    logic [STEP_W-1:0] step_reg;
    logic              m_valid_reg;
    logic [7:0]        m_data_reg;
    logic [1:0]        m_user_reg;
    logic              m_last_reg;

    logic              adv;
    logic [1:0]        sub_num;
    logic              digit_phase;
    logic [7:0]        cur_byte;
    logic [1:0]        cur_kind;
    logic              cur_last;

    assign adv         = act_reg & (~m_valid_reg | m_tready);
    assign pop         = ~q_stat.empty & (~act_reg | (adv & cur_last));
    // Number steps two onwards sit two places off a four-byte boundary.
    assign sub_num     = step_reg[1:0] ^ 2'b10;
    assign digit_phase = (step_reg >= STEP_W'(6)) && (step_reg < STEP_W'(STOP_STEP));

    always_comb begin
        cur_kind = BUS_BYTE;
        cur_byte = '0;
        cur_last = 1'b0;
        unique case (kind_reg)
            REC_NUM: begin
                if (step_reg == STEP_W'(0)) begin
                    cur_kind = BUS_START;
                end else if (step_reg == STEP_W'(1)) begin
                    cur_byte = addr_reg;
                end else if (step_reg < STEP_W'(6)) begin
                    cur_byte = lcd_byte(CURSOR_CMD, 1'b0, sub_num);
                end else if (digit_phase) begin
                    cur_byte = lcd_byte(ASCII_ZERO + {4'h0, bcd_reg[DIG_W-1 -: 4]},
                                        1'b1, sub_num);
                end else begin
                    cur_kind = BUS_STOP;
                    cur_last = 1'b1;
                end
            end
            REC_DATA: begin
                cur_byte = lcd_byte(byte_reg, 1'b1, step_reg[1:0]);
                cur_last = (step_reg == STEP_W'(3));
            end
            default: begin
                cur_byte = lcd_byte(byte_reg, 1'b0, step_reg[1:0]);
                cur_last = (step_reg == STEP_W'(3));
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= ADDR_RESET;
            act_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                addr_reg <= cfg_wdata;
            end
            if (pop) begin
                act_reg <= 1'b1;
            end else if (adv && cur_last) begin
                act_reg <= 1'b0;
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg <= rec_kind_t'(head_data[1:0]);
            byte_reg <= head_data[BYTE_W+1:2];
            bcd_reg  <= head_data[DIG_W+BYTE_W+1:BYTE_W+2];
            step_reg <= '0;
        end else if (adv) begin
            step_reg <= step_reg + 1'b1;
            if (digit_phase && sub_num == 2'b11) begin
                bcd_reg <= bcd_reg << 4;
            end
        end
        if (adv) begin
            m_data_reg <= cur_byte;
            m_user_reg <= cur_kind;
            m_last_reg <= cur_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* design/char_lcd_expander_byte_writer.sv */
// Path: a command or data word passes a queue entry, the back end's record registers and the
// output register; a number word first goes through BCD conversion and a hold register.
// Throughput: one word per cycle unless stalled; command or data makes 4, number 7 + 4*DIGITS.
// The conversion runs two bits a cycle and overlaps the output of the previous run.
// Reset: synchronous on aresetn low; queue emptied, output invalid, address back to 78.
module char_lcd_expander_byte_writer
    import clebw_pkg::*;
#(
    parameter int DIGITS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: the expander bus address used by the number sequence.
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] byte_value, [39:8] number_value
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // Output words towards the serial bus engine.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] bus_byte
    output logic [1:0]  m_tuser,   // [1:0] bus_kind
    output logic        m_tlast    // last_of_run
);

    // A queue record carries the kind of work, the LCD byte and, for a number,
    // its low DIGITS decimal digits already in BCD.
    localparam int REC_W = 4 * DIGITS + BYTE_W + 2;

    logic             push_valid;
    logic [REC_W-1:0] push_data;
    logic             pop;
    logic [REC_W-1:0] head_data;
    q_stat_t          q_stat;

    // The front end takes input words, drops the unused opcode and converts
    // numbers to BCD by shift-and-add-3. Because the conversion keeps every
    // decimal digit of the 32-bit value, taking the low DIGITS of them gives
    // the value modulo ten to the DIGITS with no divider at all.
    clebw_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_data  (push_data),
        .q_stat     (q_stat)
    );

    // Two-entry queue, so the front end can convert the next number while
    // the back end is still spelling out the previous one.
    clebw_queue #(
        .W (REC_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (pop),
        .head_data  (head_data),
        .q_stat     (q_stat)
    );

    // The back end steps through the expander bytes of each record and holds
    // them in an output register, taking the next record as the last word of
    // the current one is issued.
    clebw_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .head_data (head_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* design/clebw_checker.sv */
module clebw_checker
    import clebw_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_start_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == BUS_START |-> m_tdata == 8'd0 && !m_tlast)
        else $error("bad start word");

    a_stop_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == BUS_STOP |-> m_tdata == 8'd0 && m_tlast)
        else $error("stop word must end the run with zero data");

    a_kind_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == BUS_START || m_tuser == BUS_BYTE || m_tuser == BUS_STOP)
        else $error("unknown bus kind");

endmodule

bind char_lcd_expander_byte_writer clebw_checker u_clebw_checker (.*);

/* tb/testbench.sv */
module testbench;
    import clebw_pkg::*;

    // Digits shown by a number word; the block is built with the same count.
    localparam int SHOWN_DIGITS = 6;
    // The opcode that the block must swallow without producing anything.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Enable and register-select positions inside an expander byte.
    localparam logic [7:0] EN_MASK  = 8'h04;
    localparam logic [7:0] RS_MASK  = 8'h01;
    localparam logic [7:0] NIB_MASK = 8'hF0;
    // Quiet cycles after the last predicted word, so that the block is idle
    // before the address register is touched.
    localparam int DRAIN_CYCLES = 40;
    // Long hold-off of the receiver, made once so that the block backs up.
    localparam int HOLD_CYCLES = 400;
    // Cycles without any handshake before the run is declared hung.
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_WORDS = 100;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } bus_word_t;

    // Predicts the expander bus words and compares them in order.
    class lcd_bus_scoreboard;
        bus_word_t   due_q[$];
        logic [7:0]  address;
        int unsigned faults;
        int unsigned seen;

        function new();
            address = ADDR_RESET;
            faults  = 0;
            seen    = 0;
        endfunction

        function void set_address(logic [7:0] a);
            address = a;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void push(logic [1:0] kind, logic [7:0] data, logic last);
            bus_word_t w;
            w.kind = kind;
            w.data = data;
            w.last = last;
            due_q.push_back(w);
        endfunction

        // One LCD byte is four expander bytes: each nibble strobed high then low.
        function void push_lcd(logic [7:0] d, logic rs, logic last);
            logic [7:0] hi;
            logic [7:0] lo;
            logic [7:0] rs_bits;
            hi      = d & NIB_MASK;
            lo      = {d[3:0], 4'h0};
            rs_bits = rs ? RS_MASK : 8'h00;
            push(BUS_BYTE, hi | EN_MASK | rs_bits, 1'b0);
            push(BUS_BYTE, hi | rs_bits, 1'b0);
            push(BUS_BYTE, lo | EN_MASK | rs_bits, 1'b0);
            push(BUS_BYTE, lo | rs_bits, last);
        endfunction

        function void note_word(logic [1:0] op, logic [7:0] d, logic [31:0] n);
            longint unsigned shown;
            longint unsigned scale;
            logic [7:0]      digit;
            case (op)
                OP_CMD:  push_lcd(d, 1'b0, 1'b1);
                OP_DATA: push_lcd(d, 1'b1, 1'b1);
                OP_NUM: begin
                    scale = 1;
                    for (int i = 0; i < SHOWN_DIGITS; i++) scale = scale * 10;
                    shown = longint'(n) % scale;
                    push(BUS_START, 8'h00, 1'b0);
                    push(BUS_BYTE, address, 1'b0);
                    push_lcd(CURSOR_CMD, 1'b0, 1'b0);
                    for (int i = 0; i < SHOWN_DIGITS; i++) begin
                        scale = scale / 10;
                        digit = 8'((shown / scale) % 10);
                        push_lcd(ASCII_ZERO + digit, 1'b1, 1'b0);
                    end
                    push(BUS_STOP, 8'h00, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [1:0] kind, logic [7:0] data, logic last);
            bus_word_t want;
            seen++;
            if (due_q.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("bus word %0d unexpected: kind %0d byte %02h last %0b",
                             seen, kind, data, last);
                return;
            end
            want = due_q.pop_front();
            if (want.kind !== kind || want.data !== data || want.last !== last) begin
                faults++;
                if (faults <= 10)
                    $display("bus word %0d: expected kind %0d byte %02h last %0b,",
                             seen, want.kind, want.data, want.last,
                             " got kind %0d byte %02h last %0b", kind, data, last);
            end
        endfunction
    endclass

    // Every input of the block holds a known value from time zero.
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = OP_CMD;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    lcd_bus_scoreboard sb;

    // Remaining words of a stretch without idling, one count per side.
    int send_calm = 0;
    int take_calm = 0;
    int unsigned quiet_cycles = 0;

    always #1 aclk = ~aclk;

    char_lcd_expander_byte_writer #(
        .DIGITS(SHOWN_DIGITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Idle cycles before the next word. Now and then a stretch of back-to-back
    // words is started, so that the block also sees its full rate.
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // Values near the six-digit wrap and the 32-bit limit matter more than the
    // bulk of the range, so they get a good share of the draws.
    function automatic logic [31:0] random_number();
        logic [31:0] k;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 999999);
            2: begin
                k = $urandom_range(0, 4294);
                return k * 32'd1000000 + 32'($urandom_range(0, 6)) - 32'd3;
            end
            3: return 32'hFFFF_FFFF - $urandom_range(0, 20);
            default: return $urandom_range(0, 99);
        endcase
    endfunction

    // Monitor: every accepted word on either side goes to the scoreboard. Both
    // sides are sampled at the rising edge, before any update of that edge lands.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_word(s_tuser, s_tdata[7:0], s_tdata[39:8]);
            if (m_tvalid && m_tready)
                sb.check_word(m_tuser, m_tdata, m_tlast);
        end
    end

    // Watchdog: a correct run never goes this long without a handshake.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one word and returns in the time step of its acceptance. The valid
    // is only lowered when a gap follows, so back-to-back words keep it high.
    task automatic send_word(logic [1:0] op, logic [7:0] d, logic [31:0] n);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {n, d};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering and waits until every predicted bus word has come out,
    // then lets an unused-opcode word or a late conversion run out as well.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // The address register is only written with the block idle.
    task automatic write_address(logic [7:0] a);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_address(a);
    endtask

    // Random words: most are real commands, characters and numbers; a few carry
    // the unused opcode and must vanish without a trace.
    task automatic run_phase(int count);
        int          pick;
        logic [1:0]  op;
        repeat (count) begin
            pick = $urandom_range(0, 15);
            if (pick < 5)
                op = OP_CMD;
            else if (pick < 10)
                op = OP_DATA;
            else if (pick < 15)
                op = OP_NUM;
            else
                op = OP_UNUSED;
            send_word(op, 8'($urandom), random_number());
        end
    endtask

    // Receiver: before each word it waits a drawn number of cycles with tready
    // low. Once, at a random point of the first random phase, it holds off for a
    // long stretch so that the block's internal queue fills and it stalls its input.
    initial begin
        int taken;
        int hold_at;
        int stall;
        taken   = 0;
        hold_at = $urandom_range(400, 900);
        wait (aresetn);
        forever begin
            stall = (taken == hold_at) ? HOLD_CYCLES : draw_gap(take_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    // Main sequence: reset, directed words under the reset address, then random
    // phases under several addresses, the extremes among them.
    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Commands and characters at the byte extremes; the number field is
        // ignored for these, so it carries noise, zero and all ones.
        send_word(OP_CMD,  8'h00, 32'hFFFF_FFFF);
        send_word(OP_CMD,  8'hFF, $urandom);
        send_word(OP_CMD,  8'hA5, 32'h0000_0000);
        send_word(OP_DATA, 8'h00, $urandom);
        send_word(OP_DATA, 8'hFF, 32'hFFFF_FFFF);
        send_word(OP_DATA, 8'h5A, $urandom);
        // Numbers: zero, the largest six-digit value, the first values that
        // wrap, the 32-bit maximum and a few ordinary ones. The byte field is
        // ignored here and carries assorted values.
        send_word(OP_NUM, 8'hFF, 32'd0);
        send_word(OP_NUM, 8'h00, 32'd999999);
        send_word(OP_NUM, 8'hFF, 32'd1000000);
        send_word(OP_NUM, 8'h3C, 32'd1000001);
        send_word(OP_NUM, 8'hFF, 32'hFFFF_FFFF);
        send_word(OP_NUM, 8'h81, 32'd123456);
        send_word(OP_NUM, 8'h00, 32'd987654321);
        send_word(OP_NUM, 8'hFF, 32'd9);
        // The unused opcode twice, each followed by a word that does produce output.
        send_word(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        send_word(OP_CMD,    8'h01, $urandom);
        send_word(OP_UNUSED, 8'h00, 32'd0);
        send_word(OP_NUM,    8'h55, 32'd42);

        write_address(8'h00);
        run_phase(PHASE_WORDS);
        write_address(8'hFF);
        run_phase(PHASE_WORDS);
        write_address(8'($urandom_range(1, 254)));
        run_phase(PHASE_WORDS);
        write_address(8'($urandom_range(1, 254)));
        run_phase(PHASE_WORDS);
        write_address(ADDR_RESET);
        run_phase(PHASE_WORDS);

        settle();
        if (sb.faults == 0 && sb.pending() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
